@@ hdl/vnq12_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnq12_pkg
// shared widths, the reciprocal square root rom and a helper function
// ----------------------------------------------------------------------------
package vnq12_pkg;

    localparam int COMP_W    = 16;
    localparam int UNIT_W    = 28;
    localparam int SQ_W      = 32;
    localparam int ROM_W     = 13;
    localparam int ROM_DEPTH = 192;
    localparam int ROM_BASE  = 64;
    localparam int NORM_POS  = 24;
    localparam int PROD_W    = COMP_W + ROM_W;
    localparam int LZ_W      = 6;
    localparam int SH_W      = 4;

    typedef logic [ROM_W-1:0] rom_word_t;

    localparam rom_word_t RSQRT_ROM [0:ROM_DEPTH-1] = '{
        13'd4096, 13'd4064, 13'd4033, 13'd4003, 13'd3973, 13'd3944, 13'd3916, 13'd3888,
        13'd3861, 13'd3835, 13'd3809, 13'd3783, 13'd3758, 13'd3734, 13'd3710, 13'd3686,
        13'd3663, 13'd3640, 13'd3618, 13'd3596, 13'd3575, 13'd3554, 13'd3533, 13'd3513,
        13'd3493, 13'd3473, 13'd3454, 13'd3435, 13'd3416, 13'd3397, 13'd3379, 13'd3361,
        13'd3344, 13'd3327, 13'd3310, 13'd3293, 13'd3276, 13'd3260, 13'd3244, 13'd3228,
        13'd3213, 13'd3197, 13'd3182, 13'd3167, 13'd3153, 13'd3138, 13'd3124, 13'd3110,
        13'd3096, 13'd3082, 13'd3069, 13'd3055, 13'd3042, 13'd3029, 13'd3016, 13'd3003,
        13'd2991, 13'd2978, 13'd2966, 13'd2954, 13'd2942, 13'd2930, 13'd2919, 13'd2907,
        13'd2896, 13'd2885, 13'd2873, 13'd2862, 13'd2852, 13'd2841, 13'd2830, 13'd2820,
        13'd2809, 13'd2799, 13'd2789, 13'd2779, 13'd2769, 13'd2759, 13'd2749, 13'd2740,
        13'd2730, 13'd2721, 13'd2711, 13'd2702, 13'd2693, 13'd2684, 13'd2675, 13'd2666,
        13'd2657, 13'd2649, 13'd2640, 13'd2631, 13'd2623, 13'd2615, 13'd2606, 13'd2598,
        13'd2590, 13'd2582, 13'd2574, 13'd2566, 13'd2558, 13'd2550, 13'd2543, 13'd2535,
        13'd2528, 13'd2520, 13'd2513, 13'd2505, 13'd2498, 13'd2491, 13'd2484, 13'd2477,
        13'd2469, 13'd2462, 13'd2456, 13'd2449, 13'd2442, 13'd2435, 13'd2428, 13'd2422,
        13'd2415, 13'd2409, 13'd2402, 13'd2396, 13'd2389, 13'd2383, 13'd2377, 13'd2371,
        13'd2364, 13'd2358, 13'd2352, 13'd2346, 13'd2340, 13'd2334, 13'd2328, 13'd2322,
        13'd2317, 13'd2311, 13'd2305, 13'd2299, 13'd2294, 13'd2288, 13'd2283, 13'd2277,
        13'd2272, 13'd2266, 13'd2261, 13'd2255, 13'd2250, 13'd2245, 13'd2239, 13'd2234,
        13'd2229, 13'd2224, 13'd2219, 13'd2214, 13'd2209, 13'd2204, 13'd2199, 13'd2194,
        13'd2189, 13'd2184, 13'd2179, 13'd2174, 13'd2170, 13'd2165, 13'd2160, 13'd2155,
        13'd2151, 13'd2146, 13'd2142, 13'd2137, 13'd2133, 13'd2128, 13'd2124, 13'd2119,
        13'd2115, 13'd2110, 13'd2106, 13'd2102, 13'd2097, 13'd2093, 13'd2089, 13'd2084,
        13'd2080, 13'd2076, 13'd2072, 13'd2068, 13'd2064, 13'd2060, 13'd2056, 13'd2052
    };

    // leading zeros of a 32-bit word, 0..32
    function automatic logic [LZ_W-1:0] count_lz(input logic [SQ_W-1:0] v);
        logic [LZ_W-1:0] n;
        n = LZ_W'(SQ_W);
        for (int i = 0; i < SQ_W; i++) begin
            if (v[i]) begin
                n = LZ_W'(SQ_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

@@ hdl/vector_normalize_q12.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalize_q12
// scales a signed 3-component vector to about unit length in q12
// ----------------------------------------------------------------------------
// input channel s_valid/s_ready carries s_vec_x, s_vec_y, s_vec_z, 16-bit
// signed. result channel m_valid/m_ready carries m_unit_x, m_unit_y,
// m_unit_z, 28-bit signed q12. one result per item, in order.
// five register stages: squares, wrapping sum, normalize and rom lookup,
// multiply, shift; m_valid is the valid bit of the shift stage.
// throughput is one item per cycle while the receiver does not stall;
// the three 16x13 multipliers and the squaring multipliers each have a
// stage of their own.
// a zero vector or a sum that wraps negative gives an all-zero result.
// each stage holds its item while the next one is full, so a stalled
// receiver backs the pipe up stage by stage; empty stages still fill and
// s_ready stays high until all five stages hold an item.
// aresetn clears all valid bits; nothing else needs reset.
// ----------------------------------------------------------------------------
module vector_normalize_q12 (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [vnq12_pkg::COMP_W-1:0]  s_vec_x,
    input  logic signed [vnq12_pkg::COMP_W-1:0]  s_vec_y,
    input  logic signed [vnq12_pkg::COMP_W-1:0]  s_vec_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [vnq12_pkg::UNIT_W-1:0]  m_unit_x,
    output logic signed [vnq12_pkg::UNIT_W-1:0]  m_unit_y,
    output logic signed [vnq12_pkg::UNIT_W-1:0]  m_unit_z
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    logic signed [vnq12_pkg::COMP_W-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [vnq12_pkg::COMP_W-1:0] x2_reg, y2_reg, z2_reg;
    logic signed [vnq12_pkg::COMP_W-1:0] x3_reg, y3_reg, z3_reg;
    logic [vnq12_pkg::SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [vnq12_pkg::SQ_W-1:0] sum_reg, sum_next;

    logic                        ok3_reg, ok3_next;
    vnq12_pkg::rom_word_t        rom3_reg, rom3_next;
    logic [vnq12_pkg::SH_W-1:0]  sh3_reg, sh3_next, sh4_reg;
    logic [vnq12_pkg::LZ_W-1:0]  lz;
    logic [vnq12_pkg::SQ_W+7:0]  win;
    logic [7:0]                  norm;
    logic [7:0]                  idx;

    logic signed [vnq12_pkg::PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [vnq12_pkg::PROD_W-1:0] px_next, py_next, pz_next;

    logic signed [vnq12_pkg::UNIT_W-1:0] ux_reg, uy_reg, uz_reg;
    logic signed [vnq12_pkg::UNIT_W-1:0] ux_next, uy_next, uz_next;
    logic signed [vnq12_pkg::PROD_W-1:0] shx, shy, shz;

    assign en5 = !v5_reg || m_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    // stage 2 sum, then stage 3 logic: normalize and look up
    assign sum_next = sqx_reg + sqy_reg + sqz_reg;
    always_comb begin
        lz       = vnq12_pkg::count_lz(sum_reg) & ~vnq12_pkg::LZ_W'(1);
        win      = {sum_reg, 8'd0} >> (vnq12_pkg::LZ_W'(vnq12_pkg::SQ_W) - lz);
        norm     = win[7:0];
        idx      = norm - 8'(vnq12_pkg::ROM_BASE);
        ok3_next = !sum_reg[vnq12_pkg::SQ_W-1] && (sum_reg != '0)
                   && (norm >= 8'(vnq12_pkg::ROM_BASE));
        rom3_next = ok3_next ? vnq12_pkg::RSQRT_ROM[idx] : '0;
        sh3_next  = vnq12_pkg::SH_W'((vnq12_pkg::LZ_W'(31) - lz) >> 1);
    end

    // stage 4 and 5 logic
    always_comb begin
        px_next = $signed({1'b0, rom3_reg}) * x3_reg;
        py_next = $signed({1'b0, rom3_reg}) * y3_reg;
        pz_next = $signed({1'b0, rom3_reg}) * z3_reg;
        shx     = px_reg >>> sh4_reg;
        shy     = py_reg >>> sh4_reg;
        shz     = pz_reg >>> sh4_reg;
        ux_next = vnq12_pkg::UNIT_W'(shx);
        uy_next = vnq12_pkg::UNIT_W'(shy);
        uz_next = vnq12_pkg::UNIT_W'(shz);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            x1_reg  <= s_vec_x;
            y1_reg  <= s_vec_y;
            z1_reg  <= s_vec_z;
            sqx_reg <= vnq12_pkg::SQ_W'(s_vec_x * s_vec_x);
            sqy_reg <= vnq12_pkg::SQ_W'(s_vec_y * s_vec_y);
            sqz_reg <= vnq12_pkg::SQ_W'(s_vec_z * s_vec_z);
        end
        if (en2) begin
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            z2_reg  <= z1_reg;
            sum_reg <= sum_next;
        end
        if (en3) begin
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            z3_reg   <= z2_reg;
            ok3_reg  <= ok3_next;
            rom3_reg <= rom3_next;
            sh3_reg  <= sh3_next;
        end
        if (en4) begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            pz_reg  <= pz_next;
            sh4_reg <= sh3_reg;
        end
        if (en5) begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            uz_reg <= uz_next;
        end
    end

    assign m_valid  = v5_reg;
    assign m_unit_x = ux_reg;
    assign m_unit_y = uy_reg;
    assign m_unit_z = uz_reg;

`ifndef SYNTHESIS
    a_rom_zero_when_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !ok3_reg) |-> (rom3_reg == '0))
        else $error("rom value not cleared for out-of-table item");

    a_rom_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && ok3_reg) |-> (rom3_reg >= 13'd2052 && rom3_reg <= 13'd4096))
        else $error("rom value outside table range");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_ready)
        else $error("input stalled with empty first stage");

    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && en5) |=> v5_reg)
        else $error("item lost between multiply and output stage");
`endif

endmodule
